/* hdl/snd_pkg.sv */
// Shared types, constants and letter class table for the Soundex name encoder.
`timescale 1ns / 1ps
`default_nettype none

package snd_pkg;

    // Number of Soundex digits kept after the first letter.
    localparam int CodeDigits = 3;

    // Depth of the queue between the classifier and the encoder.
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // ASCII bounds used by the classifier.
    localparam logic [7:0] AsciiUpperA = 8'h41;
    localparam logic [7:0] AsciiUpperZ = 8'h5A;
    localparam logic [7:0] AsciiLowerA = 8'h61;
    localparam logic [7:0] AsciiLowerZ = 8'h7A;
    localparam logic [7:0] CaseOffset  = 8'h20;

    // Class 0 marks vowels and H W Y: they separate runs but add no digit.
    localparam logic [2:0] ClassSeparator = 3'd0;

    // Digit class of each letter A..Z.
    localparam logic [2:0] LetterClass [26] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
        3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
    };

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic       is_letter;
        logic [6:0] upper;
        logic [2:0] cls;
        logic       last;
    } item_t;

endpackage

`default_nettype wire

/* hdl/snd_front.sv */
// Front end: classifies each raw byte into letter flag, upper-case code and digit class.
`timescale 1ns / 1ps
`default_nettype none

module snd_front
(
    input  wire logic          in_valid,
    input  wire logic [7:0]    char_in,
    input  wire logic          last_char,
    input  wire logic          queue_full,
    output snd_pkg::item_t     item,
    output logic               push,
    output logic               in_stall
);

    logic       is_upper;
    logic       is_lower;
    logic [7:0] upper_byte;
    logic [4:0] letter_index;

    // Letter detection and upper-casing.
    assign is_upper   = (char_in >= snd_pkg::AsciiUpperA) && (char_in <= snd_pkg::AsciiUpperZ);
    assign is_lower   = (char_in >= snd_pkg::AsciiLowerA) && (char_in <= snd_pkg::AsciiLowerZ);
    assign upper_byte = is_lower ? (char_in - snd_pkg::CaseOffset) : char_in;

    // Only meaningful for letters; other bytes get a harmless index.
    always_comb
    begin
        letter_index = 5'd0;
        if (is_upper || is_lower)
        begin
            letter_index = 5'(upper_byte - snd_pkg::AsciiUpperA);
        end
    end

    // Build the classified beat.
    always_comb
    begin
        item.is_letter = is_upper || is_lower;
        item.upper     = upper_byte[6:0];
        item.cls       = snd_pkg::LetterClass[letter_index];
        item.last      = last_char;
    end

    // Accept whenever the queue has room.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

endmodule

`default_nettype wire

/* hdl/snd_queue.sv */
// Short FIFO of classified beats between the front end and the encoder.
`timescale 1ns / 1ps
`default_nettype none

module snd_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire snd_pkg::item_t  push_item,
    input  wire logic            pop,
    output snd_pkg::item_t       head_item,
    output logic                 head_valid,
    output logic                 full
);

    snd_pkg::item_t                  entry_reg [snd_pkg::QueueDepth];
    logic [snd_pkg::QueuePtrW-1:0]   wr_ptr_reg;
    logic [snd_pkg::QueuePtrW-1:0]   wr_ptr_next;
    logic [snd_pkg::QueuePtrW-1:0]   rd_ptr_reg;
    logic [snd_pkg::QueuePtrW-1:0]   rd_ptr_next;
    logic [snd_pkg::QueueCntW-1:0]   count_reg;
    logic [snd_pkg::QueueCntW-1:0]   count_next;

    assign head_item  = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == snd_pkg::QueueCntW'(snd_pkg::QueueDepth));

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + snd_pkg::QueuePtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + snd_pkg::QueuePtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + snd_pkg::QueueCntW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - snd_pkg::QueueCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/snd_back.sv */
// Back end: folds classified beats into the Soundex code and holds the result beat.
`timescale 1ns / 1ps
`default_nettype none

module snd_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire snd_pkg::item_t  head_item,
    input  wire logic            head_valid,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [6:0]           code_letter,
    output logic [2:0]           code_digit_one,
    output logic [2:0]           code_digit_two,
    output logic [2:0]           code_digit_three,
    output logic                 no_letters
);

    logic       seen_letter_reg;
    logic       seen_letter_next;
    logic [6:0] held_letter_reg;
    logic [6:0] held_letter_next;
    logic [2:0] previous_class_reg;
    logic [2:0] previous_class_next;
    logic [1:0] digits_held_reg;
    logic [1:0] digits_held_next;
    logic [2:0] digit_store_reg  [snd_pkg::CodeDigits];
    logic [2:0] digit_store_next [snd_pkg::CodeDigits];

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] code_letter_reg;
    logic [2:0] digit_one_reg;
    logic [2:0] digit_two_reg;
    logic [2:0] digit_three_reg;
    logic       no_letters_reg;
    logic       emit;

    // Take a beat unless it would finish a name while the result register is still held.
    assign pop  = head_valid && !(head_item.last && out_valid_reg && out_stall);
    assign emit = pop && head_item.last;

    // Encoder state update for one letter.
    always_comb
    begin
        seen_letter_next    = seen_letter_reg;
        held_letter_next    = held_letter_reg;
        previous_class_next = previous_class_reg;
        digits_held_next    = digits_held_reg;
        digit_store_next    = digit_store_reg;
        if (pop && head_item.is_letter)
        begin
            if (!seen_letter_reg)
            begin
                seen_letter_next    = 1'b1;
                held_letter_next    = head_item.upper;
                previous_class_next = head_item.cls;
            end
            else if (head_item.cls != previous_class_reg)
            begin
                previous_class_next = head_item.cls;
                if ((head_item.cls != snd_pkg::ClassSeparator) &&
                    (digits_held_reg < 2'(snd_pkg::CodeDigits)))
                begin
                    digit_store_next[digits_held_reg] = head_item.cls;
                    digits_held_next = digits_held_reg + 2'd1;
                end
            end
        end
    end

    // Encoder state registers; a finished name clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_letter_reg    <= 1'b0;
            held_letter_reg    <= '0;
            previous_class_reg <= '0;
            digits_held_reg    <= '0;
            for (int i = 0; i < snd_pkg::CodeDigits; i++)
            begin
                digit_store_reg[i] <= '0;
            end
        end
        else if (emit)
        begin
            seen_letter_reg    <= 1'b0;
            held_letter_reg    <= '0;
            previous_class_reg <= '0;
            digits_held_reg    <= '0;
            for (int i = 0; i < snd_pkg::CodeDigits; i++)
            begin
                digit_store_reg[i] <= '0;
            end
        end
        else
        begin
            seen_letter_reg    <= seen_letter_next;
            held_letter_reg    <= held_letter_next;
            previous_class_reg <= previous_class_next;
            digits_held_reg    <= digits_held_next;
            digit_store_reg    <= digit_store_next;
        end
    end

    // Result beat valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; a name without letters leaves the letter and digit fields at zero.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            code_letter_reg <= seen_letter_next ? held_letter_next : 7'd0;
            digit_one_reg   <= seen_letter_next ? digit_store_next[0] : 3'd0;
            digit_two_reg   <= seen_letter_next ? digit_store_next[1] : 3'd0;
            digit_three_reg <= seen_letter_next ? digit_store_next[2] : 3'd0;
            no_letters_reg  <= !seen_letter_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign code_letter      = code_letter_reg;
    assign code_digit_one   = digit_one_reg;
    assign code_digit_two   = digit_two_reg;
    assign code_digit_three = digit_three_reg;
    assign no_letters       = no_letters_reg;

endmodule

`default_nettype wire

/* hdl/soundex_name_encoder.sv */
// Top level: Soundex name encoder with classifier, beat queue and encoder back end.
// Throughput: one byte beat per cycle while the queue has room; the encoder folds one queued beat
// each cycle unless a finished name waits on a stalled result beat. A last byte is written into
// the queue, then popped by the encoder into the result register, which raises out_valid.
// A four-entry queue lets up to four input beats flow while a result beat is stalled.
// Reset (rst_n low, asynchronous) empties the queue and clears the encoder state.
`timescale 1ns / 1ps
`default_nettype none

module soundex_name_encoder
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    char_in,
    input  wire logic          last_char,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [6:0]         code_letter,
    output logic [2:0]         code_digit_one,
    output logic [2:0]         code_digit_two,
    output logic [2:0]         code_digit_three,
    output logic               no_letters
);

    snd_pkg::item_t front_item;
    snd_pkg::item_t head_item;
    logic           push;
    logic           pop;
    logic           head_valid;
    logic           queue_full;

    // Byte classifier.
    snd_front u_front
    (
        .in_valid   (in_valid),
        .char_in    (char_in),
        .last_char  (last_char),
        .queue_full (queue_full),
        .item       (front_item),
        .push       (push),
        .in_stall   (in_stall)
    );

    // Beat queue between classifier and encoder.
    snd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    // Code builder and result register.
    snd_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_item        (head_item),
        .head_valid       (head_valid),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .code_letter      (code_letter),
        .code_digit_one   (code_digit_one),
        .code_digit_two   (code_digit_two),
        .code_digit_three (code_digit_three),
        .no_letters       (no_letters)
    );

endmodule

`default_nettype wire

/* tb/tb_soundex_name_encoder.sv */
// Self-checking testbench for the Soundex name encoder: byte stimulus, code prediction, checks.
`timescale 1ns / 1ps

module tb_soundex_name_encoder;

    localparam int IdleLimit   = 2000;
    localparam int PhaseBytes  = 317;
    localparam int DrainCycles = 8;

    // One four-character Soundex code as the block reports it.
    typedef struct packed {
        logic [6:0] letter;
        logic [2:0] digit_one;
        logic [2:0] digit_two;
        logic [2:0] digit_three;
        logic       no_letter;
    } soundex_code_t;

    // Tracks the name being spelled and holds the codes still owed by the block.
    class soundex_tracker;
        bit             seen;
        logic [6:0]     first_letter;
        logic [2:0]     prior_class;
        int             digit_count;
        logic [2:0]     digits [snd_pkg::CodeDigits];
        soundex_code_t  owed_codes [$];
        int             error_count;

        function new();
            error_count = 0;
            clear_name();
        endfunction

        function void clear_name();
            seen = 1'b0;
            first_letter = '0;
            prior_class = snd_pkg::ClassSeparator;
            digit_count = 0;
            foreach (digits[i])
                digits[i] = '0;
        endfunction

        // Digit class of an upper-case letter; vowels and H W Y separate runs.
        function logic [2:0] class_of(logic [7:0] up);
            case (up)
                "B", "F", "P", "V":                     return 3'd1;
                "C", "G", "J", "K", "Q", "S", "X", "Z": return 3'd2;
                "D", "T":                               return 3'd3;
                "L":                                    return 3'd4;
                "M", "N":                               return 3'd5;
                "R":                                    return 3'd6;
                default:                                return snd_pkg::ClassSeparator;
            endcase
        endfunction

        // Fold one accepted byte beat into the name; a last byte yields a code.
        function void note_byte(logic [7:0] b, logic is_last);
            logic [7:0]    up;
            logic [2:0]    cls;
            bit            is_letter;
            soundex_code_t code;
            is_letter = 1'b1;
            up = b;
            if (b >= "a" && b <= "z")
                up = b - snd_pkg::CaseOffset;
            else if (!(b >= "A" && b <= "Z"))
                is_letter = 1'b0;

            if (is_letter)
            begin
                cls = class_of(up);
                if (!seen)
                begin
                    seen = 1'b1;
                    first_letter = up[6:0];
                    prior_class = cls;
                end
                else if (cls != prior_class)
                begin
                    if (cls != snd_pkg::ClassSeparator && digit_count < snd_pkg::CodeDigits)
                    begin
                        digits[digit_count] = cls;
                        digit_count++;
                    end
                    prior_class = cls;
                end
            end

            if (is_last)
            begin
                code = '0;
                if (seen)
                begin
                    code.letter = first_letter;
                    code.digit_one = digits[0];
                    code.digit_two = digits[1];
                    code.digit_three = digits[2];
                end
                else
                    code.no_letter = 1'b1;
                owed_codes.push_back(code);
                clear_name();
            end
        endfunction

        // Compare a result beat with the oldest code still owed.
        function void check_code(logic [6:0] letter, logic [2:0] d1, logic [2:0] d2,
                                 logic [2:0] d3, logic none);
            soundex_code_t want;
            if (owed_codes.size() == 0)
            begin
                $error("result beat arrived with no code pending");
                error_count++;
                return;
            end
            want = owed_codes.pop_front();
            if (letter !== want.letter)
            begin
                $error("code_letter: expected %0d, got %0d", want.letter, letter);
                error_count++;
            end
            if (d1 !== want.digit_one)
            begin
                $error("code_digit_one: expected %0d, got %0d", want.digit_one, d1);
                error_count++;
            end
            if (d2 !== want.digit_two)
            begin
                $error("code_digit_two: expected %0d, got %0d", want.digit_two, d2);
                error_count++;
            end
            if (d3 !== want.digit_three)
            begin
                $error("code_digit_three: expected %0d, got %0d", want.digit_three, d3);
                error_count++;
            end
            if (none !== want.no_letter)
            begin
                $error("no_letters: expected %0d, got %0d", want.no_letter, none);
                error_count++;
            end
        endfunction

        function int pending();
            return owed_codes.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       last_char;
    logic       out_valid;
    logic       out_stall;
    logic [6:0] code_letter;
    logic [2:0] code_digit_one;
    logic [2:0] code_digit_two;
    logic [2:0] code_digit_three;
    logic       no_letters;

    soundex_tracker tracker;
    int send_gap_pct;
    int recv_stall_pct;
    int idle_run;
    int sent_bytes;

    soundex_name_encoder DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_in          (char_in),
        .last_char        (last_char),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .code_letter      (code_letter),
        .code_digit_one   (code_digit_one),
        .code_digit_two   (code_digit_two),
        .code_digit_three (code_digit_three),
        .no_letters       (no_letters)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver back-pressure changes on the falling edge.
    always @(negedge clk)
        out_stall = ($urandom_range(99) < recv_stall_pct);

    // Check result beats and watch for a stuck block at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && !out_stall)
                tracker.check_code(code_letter, code_digit_one, code_digit_two,
                                   code_digit_three, no_letters);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= IdleLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Present one byte beat, with random gaps before it, and hold it until taken.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            char_in = 8'($urandom);
            last_char = 1'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        char_in = b;
        last_char = is_last;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_byte(b, is_last);
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Mostly letters of either case, with some arbitrary bytes mixed in.
    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        if ($urandom_range(99) < 80)
        begin
            b = 8'($urandom_range("Z", "A"));
            if ($urandom_range(1))
                b = b + snd_pkg::CaseOffset;
        end
        else
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // A random name: usually short and well formed, sometimes long, sometimes noise.
    task automatic send_random_name();
        int len;
        bit noise;
        len = ($urandom_range(99) < 6) ? $urandom_range(20, 12) : $urandom_range(8, 1);
        noise = ($urandom_range(99) < 10);
        for (int i = 0; i < len; i++)
            send_byte(noise ? 8'($urandom) : name_byte(), i == len - 1);
    endtask

    // Hold the sender until every owed code has come back.
    task automatic wait_for_codes();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int gap_pct, input int stall_pct);
        int target;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        target = sent_bytes + PhaseBytes;
        while (sent_bytes < target)
            send_random_name();
        wait_for_codes();
    endtask

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_in = '0;
        last_char = 1'b0;
        out_stall = 1'b0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        idle_run = 0;
        sent_bytes = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed names: single letters, names with no letter, byte extremes,
        // every digit class, a run that merges with the first letter, truncation.
        send_text("a");
        send_text("Z");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h40, 1'b0);
        send_byte(8'h5B, 1'b0);
        send_byte(8'h60, 1'b0);
        send_byte(8'h7B, 1'b0);
        send_byte(8'h80, 1'b1);
        send_text("Ashcraft");
        send_text("Bmlz");
        send_text("Bf");
        wait_for_codes();

        run_phase(11, 67);
        run_phase(67, 11);
        run_phase(0, 0);

        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        if (tracker.error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/snd_pkg.sv
hdl/snd_front.sv
hdl/snd_queue.sv
hdl/snd_back.sv
hdl/soundex_name_encoder.sv
tb/tb_soundex_name_encoder.sv
